@@ rtl/heading_turn_velocity_solver_top_assert.svh @@
// Assertion macros shared by the solver modules. They expect clk and arst_n in scope.
`ifndef HEADING_TURN_VELOCITY_SOLVER_TOP_ASSERT_SVH
`define HEADING_TURN_VELOCITY_SOLVER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTVS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/htvs_pkg.sv @@
package htvs_pkg;

	localparam int ANGLE_BITS_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES      = 24;

	// Width of the rotator's x and y words (Q2.30 with headroom) and of its angle word.
	localparam int CW = 34;
	localparam int ZW = 33;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [1:0] {
		REG_BASE_SPEED  = 2'd0,
		REG_BOOST_SPEED = 2'd1,
		REG_TURN_RATE   = 2'd2,
		REG_TICK_TIME   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_CFG = 2'd1,
		ST_BAD_IN  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		TURN_STRAIGHT = 2'd0,
		TURN_LEFT     = 2'd1,
		TURN_RIGHT    = 2'd2,
		TURN_INVALID  = 2'd3
	} turn_t;

	typedef struct packed {
		logic [15:0] base_speed;
		logic [15:0] boost_speed;
		logic [15:0] turn_rate;
		logic [15:0] tick_time;
	} cfg_t;

	// Side information that rides along with the rotator.
	typedef struct packed {
		status_t     status;
		logic [15:0] heading;
		logic [15:0] speed;
		logic        flip;
	} side_t;

	function automatic logic [31:0] atan_val(input int unsigned idx);
		logic [31:0] r;
		case (idx)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051D;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2E;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2F9;
			15: r = 32'h0000517C;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A2F;
			19: r = 32'h00000517;
			20: r = 32'h0000028B;
			21: r = 32'h00000145;
			22: r = 32'h000000A2;
			23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/heading_turn_velocity_solver_top.sv @@
// Every rotation step and the speed multiply own a register stage.
// Throughput: one beat per cycle while the output is not stalled.
// A stall at the output holds the whole pipeline in place; nothing is dropped or repeated.
// Reset: arst_n clears all valid bits at once and loads the configuration registers with their defaults.
// No clearing pass follows reset, so the block takes input from the first cycle after release.
`include "heading_turn_velocity_solver_top_assert.svh"

module heading_turn_velocity_solver_top
	import htvs_pkg::*;
#(
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// heading[15:0], turn[17:16], boost[18], zero padding[23:19]
	input  logic [23:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// new_heading[15:0], dir_x[31:16], dir_y[47:32], speed_out[63:48],
	// vel_x[80:64], vel_y[97:81], zero padding[103:98]
	output logic [103:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]   m_axis_tuser
);

	cfg_t cfg_q;

	logic                 adv;
	logic                 vld_t;
	side_t                side_t2;
	logic signed [ZW-1:0] z_t;
	logic                 vld_c;
	side_t                side_c;
	logic signed [CW-1:0] x_c;
	logic signed [CW-1:0] y_c;

	status_t            status_o;
	logic [15:0]        nh_o;
	logic signed [15:0] dx_o;
	logic signed [15:0] dy_o;
	logic [15:0]        sp_o;
	logic signed [16:0] vx_o;
	logic signed [16:0] vy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_speed  <= 16'd256;
			cfg_q.boost_speed <= 16'd512;
			cfg_q.turn_rate   <= 16'd8192;
			cfg_q.tick_time   <= 16'd1092;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_BASE_SPEED:  cfg_q.base_speed  <= cfg_data;
				REG_BOOST_SPEED: cfg_q.boost_speed <= cfg_data;
				REG_TURN_RATE:   cfg_q.turn_rate   <= cfg_data;
				REG_TICK_TIME:   cfg_q.tick_time   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	htvs_turn #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_turn (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cfg    (cfg_q),
		.in_vld (s_axis_tvalid),
		.heading(s_axis_tdata[15:0]),
		.turn   (turn_t'(s_axis_tdata[17:16])),
		.boost  (s_axis_tdata[18]),
		.vld_s2 (vld_t),
		.side_s2(side_t2),
		.z_s2   (z_t)
	);

	htvs_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_in  (vld_t),
		.side_in (side_t2),
		.z_in    (z_t),
		.vld_out (vld_c),
		.side_out(side_c),
		.x_out   (x_c),
		.y_out   (y_c)
	);

	htvs_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_c),
		.side_in  (side_c),
		.x_in     (x_c),
		.y_in     (y_c),
		.vld_s2   (m_axis_tvalid),
		.status_s2(status_o),
		.nh_s2    (nh_o),
		.dx_s2    (dx_o),
		.dy_s2    (dy_o),
		.sp_s2    (sp_o),
		.vx_s2    (vx_o),
		.vy_s2    (vy_o)
	);

	assign m_axis_tdata = {6'b000000, vy_o, vx_o, sp_o, dy_o, dx_o, nh_o};
	assign m_axis_tuser = status_o;

	`HTVS_ASSERT_NEXT(a_cfg_rate_write, cfg_wr_en && cfg_index == REG_TURN_RATE, cfg_q.turn_rate == $past(cfg_data), "Turn rate write not taken.")

endmodule

@@ rtl/htvs_turn.sv @@
`include "heading_turn_velocity_solver_top_assert.svh"

module htvs_turn
	import htvs_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  cfg_t                 cfg,
	input  logic                 in_vld,
	input  logic [15:0]          heading,
	input  turn_t                turn,
	input  logic                 boost,
	output logic                 vld_s2,
	output side_t                side_s2,
	output logic signed [ZW-1:0] z_s2
);

	localparam logic [31:0] KEEP = ~(32'hFFFF_FFFF >> ANGLE_BITS);

	logic        vld_s1;
	status_t     status_s1;
	logic [15:0] heading_s1;
	turn_t       turn_s1;
	logic [15:0] speed_s1;
	logic [31:0] prod_s1;

	logic        cfg_bad;
	logic        in_bad;
	status_t     status_c;
	logic [31:0] rsum;
	logic [15:0] delta;
	logic [15:0] nh;
	logic [31:0] ang;
	logic        flip;
	logic [31:0] ang_f;

	always_comb begin
		cfg_bad = (cfg.base_speed == 16'd0) || (cfg.turn_rate == 16'd0)
			|| (cfg.boost_speed < cfg.base_speed);
		in_bad = (turn == TURN_INVALID) || (cfg.tick_time == 16'd0);
		if (cfg_bad) begin
			status_c = ST_BAD_CFG;
		end else if (in_bad) begin
			status_c = ST_BAD_IN;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s1  <= status_c;
			heading_s1 <= heading;
			turn_s1    <= turn;
			speed_s1   <= boost ? cfg.boost_speed : cfg.base_speed;
			prod_s1    <= cfg.turn_rate * cfg.tick_time;
		end
	end

	always_comb begin
		rsum  = prod_s1 + 32'd32768;
		delta = rsum[31:16];
		case (turn_s1)
			TURN_LEFT:  nh = heading_s1 + delta;
			TURN_RIGHT: nh = heading_s1 - delta;
			default:    nh = heading_s1;
		endcase
		ang   = {nh, 16'h0000} & KEEP;
		flip  = ang[31] ^ ang[30];
		ang_f = {ang[31] ^ flip, ang[30:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.status  <= status_s1;
			side_s2.heading <= nh;
			side_s2.speed   <= speed_s1;
			side_s2.flip    <= flip;
			z_s2            <= {{(ZW-32){ang_f[31]}}, ang_f};
		end
	end

	`HTVS_ASSERT_NEXT(a_turn_vld_moves, en && vld_s1, vld_s2, "Valid item lost between stages.")

endmodule

@@ rtl/htvs_cordic.sv @@
module htvs_cordic
	import htvs_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  side_t                side_in,
	input  logic signed [ZW-1:0] z_in,
	output logic                 vld_out,
	output side_t                side_out,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out
);

	logic                 vld_s [0:CORDIC_STAGES];
	side_t                sd_s  [0:CORDIC_STAGES];
	logic signed [CW-1:0] x_s   [0:CORDIC_STAGES];
	logic signed [CW-1:0] y_s   [0:CORDIC_STAGES];
	logic signed [ZW-1:0] z_s   [0:CORDIC_STAGES-1];

	assign vld_s[0] = vld_in;
	assign sd_s[0]  = side_in;
	assign x_s[0]   = CORDIC_GAIN;
	assign y_s[0]   = '0;
	assign z_s[0]   = z_in;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic signed [ZW-1:0] ATAN_I = {{(ZW-32){1'b0}}, atan_val(i)};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[i+1] <= sd_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				end
			end
		end

		if (i < CORDIC_STAGES - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (en) begin
					if (!z_s[i][ZW-1]) begin
						z_s[i+1] <= z_s[i] - ATAN_I;
					end else begin
						z_s[i+1] <= z_s[i] + ATAN_I;
					end
				end
			end
		end
	end

	assign vld_out  = vld_s[CORDIC_STAGES];
	assign side_out = sd_s[CORDIC_STAGES];
	assign x_out    = x_s[CORDIC_STAGES];
	assign y_out    = y_s[CORDIC_STAGES];

endmodule

@@ rtl/htvs_scale.sv @@
`include "heading_turn_velocity_solver_top_assert.svh"

module htvs_scale
	import htvs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  side_t                side_in,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	output logic                 vld_s2,
	output status_t              status_s2,
	output logic [15:0]          nh_s2,
	output logic signed [15:0]   dx_s2,
	output logic signed [15:0]   dy_s2,
	output logic [15:0]          sp_s2,
	output logic signed [16:0]   vx_s2,
	output logic signed [16:0]   vy_s2
);

	localparam logic signed [CW-1:0] RND = CW'(32768);
	localparam logic signed [CW-1:0] LIM = CW'(16384);

	function automatic logic signed [15:0] to_q14(input logic signed [CW-1:0] v,
			input logic neg);
		logic signed [CW-1:0] r;
		logic signed [15:0]   c;
		r = (v + RND) >>> 16;
		if (r > LIM) begin
			c = 16'sd16384;
		end else if (r < -LIM) begin
			c = -16'sd16384;
		end else begin
			c = r[15:0];
		end
		return neg ? -c : c;
	endfunction

	logic               vld_s1;
	side_t              sd_s1;
	logic signed [15:0] dx_s1;
	logic signed [15:0] dy_s1;

	logic signed [32:0] px;
	logic signed [32:0] py;
	logic signed [32:0] sx;
	logic signed [32:0] sy;
	logic               ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1 <= side_in;
			dx_s1 <= to_q14(x_in, side_in.flip);
			dy_s1 <= to_q14(y_in, side_in.flip);
		end
	end

	always_comb begin
		px = dx_s1 * $signed({1'b0, sd_s1.speed});
		py = dy_s1 * $signed({1'b0, sd_s1.speed});
		sx = px >>> 14;
		sy = py >>> 14;
		ok = (sd_s1.status == ST_OK);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s2 <= sd_s1.status;
			nh_s2     <= ok ? sd_s1.heading : 16'h0000;
			dx_s2     <= ok ? dx_s1 : 16'sd0;
			dy_s2     <= ok ? dy_s1 : 16'sd0;
			sp_s2     <= ok ? sd_s1.speed : 16'h0000;
			vx_s2     <= ok ? sx[16:0] : 17'sd0;
			vy_s2     <= ok ? sy[16:0] : 17'sd0;
		end
	end

	`HTVS_ASSERT_SAME(a_err_zero, vld_s2 && status_s2 != ST_OK, nh_s2 == 16'h0000 && dx_s2 == 16'sd0 && dy_s2 == 16'sd0 && sp_s2 == 16'h0000 && vx_s2 == 17'sd0 && vy_s2 == 17'sd0, "Error beat carries nonzero data.")
	`HTVS_ASSERT_SAME(a_dir_range, vld_s2, dx_s2 <= 16'sd16384 && dx_s2 >= -16'sd16384 && dy_s2 <= 16'sd16384 && dy_s2 >= -16'sd16384, "Direction out of Q1.14 unit range.")

endmodule
